@@ hw/rtl/salru_pkg.sv @@
// Shared types and constants for the set-associative LRU cache lookup unit.
// No dependencies; imported by every module of the block.

package salru_pkg;

   localparam int ADDR_W    = 64;  // request address and stored tag width
   localparam int OP_W      = 2;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_W     = 6;   // widest configuration register
   localparam int RSP_CNT_W = 32;  // running counts as shown on the result ports
   localparam int SHIFT_W   = 7;   // holds set bits plus block bits, up to 70

   localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
   localparam logic [OP_W-1:0] OP_STORE  = 2'd1;
   localparam logic [OP_W-1:0] OP_MODIFY = 2'd2;
   localparam logic [OP_W-1:0] OP_NONE   = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_SET_BITS   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_BITS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WAYS       = 2'd2;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP,
      ST_SECOND
   } state_type;

   typedef struct packed {
      logic hit;
      logic evict;
   } lookup_flags_type;

endpackage

@@ hw/rtl/salru_lookup.sv @@
// Tag compare, victim choice and recency update for one set row.
// Depends on salru_pkg; instantiated by set_assoc_lru_cache_lookup_unit.

module salru_lookup
   import salru_pkg::*;
#(
   parameter int MAX_WAYS = 8
) (
   input  logic [$clog2(MAX_WAYS+1)-1:0]                       nways,
   input  logic [ADDR_W-1:0]                                   tag,
   input  logic [MAX_WAYS-1:0]                                 valid,
   input  logic [MAX_WAYS-1:0][(MAX_WAYS > 1 ? $clog2(MAX_WAYS) : 1)-1:0] rec,
   input  logic [MAX_WAYS-1:0][ADDR_W-1:0]                     tags,
   output lookup_flags_type                                    flags,
   output logic [MAX_WAYS-1:0]                                 new_valid,
   output logic [MAX_WAYS-1:0][(MAX_WAYS > 1 ? $clog2(MAX_WAYS) : 1)-1:0] new_rec,
   output logic [MAX_WAYS-1:0][ADDR_W-1:0]                     new_tags
);

   localparam int REC_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int WAY_W = REC_W;
   localparam int NW_W  = $clog2(MAX_WAYS + 1);
   localparam logic [REC_W-1:0] REC_MAX = REC_W'(MAX_WAYS - 1);

   logic [MAX_WAYS-1:0] in_use;
   logic [MAX_WAYS-1:0] match;
   logic                hit;
   logic [WAY_W-1:0]    hit_way;
   logic                any_empty;
   logic [WAY_W-1:0]    empty_way;
   logic [WAY_W-1:0]    lru_way;
   logic [REC_W-1:0]    lru_rec;
   logic [WAY_W-1:0]    victim;
   logic                old_valid;
   logic [REC_W-1:0]    old_rec;

   always_comb begin
      for (int w = 0; w < MAX_WAYS; w++) begin
         in_use[w] = (NW_W'(w) < nways);
         match[w]  = in_use[w] && valid[w] && (tags[w] == tag);
      end
   end

   // Lowest-numbered matching way, lowest-numbered empty way, oldest way.
   always_comb begin
      hit       = 1'b0;
      hit_way   = '0;
      any_empty = 1'b0;
      empty_way = '0;
      lru_way   = '0;
      lru_rec   = rec[0];
      for (int w = 0; w < MAX_WAYS; w++) begin
         if (!hit && match[w]) begin
            hit     = 1'b1;
            hit_way = WAY_W'(w);
         end
         if (!any_empty && in_use[w] && !valid[w]) begin
            any_empty = 1'b1;
            empty_way = WAY_W'(w);
         end
      end
      for (int w = 1; w < MAX_WAYS; w++) begin
         if (in_use[w] && (rec[w] > lru_rec)) begin
            lru_way = WAY_W'(w);
            lru_rec = rec[w];
         end
      end
   end

   always_comb begin
      priority if (hit) begin
         victim = hit_way;
      end else if (any_empty) begin
         victim = empty_way;
      end else begin
         victim = lru_way;
      end
      flags.hit   = hit;
      flags.evict = !hit && !any_empty;
      old_valid   = valid[victim];
      old_rec     = rec[victim];
   end

   // Age every valid line younger than the touched one; a fresh fill ages all.
   always_comb begin
      new_valid = valid;
      new_rec   = rec;
      new_tags  = tags;
      for (int v = 0; v < MAX_WAYS; v++) begin
         if (in_use[v] && valid[v] && (WAY_W'(v) != victim) &&
             (!old_valid || (rec[v] < old_rec)) && (rec[v] < REC_MAX)) begin
            new_rec[v] = rec[v] + 1'b1;
         end
      end
      new_rec[victim]   = '0;
      new_valid[victim] = 1'b1;
      new_tags[victim]  = tag;
   end

endmodule

@@ hw/rtl/set_assoc_lru_cache_lookup_unit.sv @@
// Set-associative cache tag lookup with LRU replacement: top level.
// Depends on salru_pkg and salru_lookup.
//
// After reset the unit runs a clearing pass over all 2**MAX_SET_BITS sets of the
// set memory, one set per cycle, with busy high. A request is taken when
// start is high and busy is low. A load or store reads the set row from the
// synchronous set memory in the accept cycle; in the cycle after, it
// compares tags, picks the victim and writes the row back. A modify gives
// two results, the second one always a hit. Operation code 3 is taken and
// gives no result. Each result shows on the rsp_ ports for one cycle with
// rsp_valid high, in the cycle after its lookup, and cannot be held off by
// the receiver. Configuration is written through the csr_ port only while
// the unit is idle; the unit does not enforce it. The running counts saturate.

module set_assoc_lru_cache_lookup_unit
   import salru_pkg::*;
#(
   parameter int MAX_SET_BITS = 6,
   parameter int MAX_WAYS     = 8,
   parameter int COUNT_WIDTH  = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_start,
   output logic                 req_busy,
   input  logic [ADDR_W-1:0]    req_address,
   input  logic [OP_W-1:0]      req_operation,
   output logic                 rsp_valid,
   output logic                 rsp_hit,
   output logic                 rsp_eviction,
   output logic                 rsp_last,
   output logic [RSP_CNT_W-1:0] rsp_hits_total,
   output logic [RSP_CNT_W-1:0] rsp_misses_total,
   output logic [RSP_CNT_W-1:0] rsp_evictions_total,
   input  logic                 csr_wen,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   localparam int NUM_SETS = 1 << MAX_SET_BITS;
   localparam int SET_W    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
   localparam int REC_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int NW_W     = $clog2(MAX_WAYS + 1);
   localparam int ST_W     = MAX_WAYS * (REC_W + 1);

   // configuration
   logic [2:0] set_bits_ff;
   logic [5:0] block_bits_ff;
   logic [3:0] ways_ff;

   // control
   state_type        state_ff, state_in;
   logic [SET_W-1:0] clr_cnt_ff;
   logic             modify_ff;
   logic [SET_W-1:0] set_ff;
   logic [ADDR_W-1:0] tag_ff;

   // counters and result
   logic [COUNT_WIDTH-1:0] hit_cnt_ff, miss_cnt_ff, evict_cnt_ff;
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_hit_ff, rsp_hit_in;
   logic rsp_evict_ff, rsp_evict_in;
   logic rsp_last_ff, rsp_last_in;
   logic hit_inc, miss_inc, evict_inc;
   logic accept;

   // set memory: tags in one array, valid bits and recency ranks in another
   logic [MAX_WAYS-1:0][ADDR_W-1:0] tag_mem [NUM_SETS];
   logic [ST_W-1:0]                 st_mem  [NUM_SETS];
   logic [MAX_WAYS-1:0][ADDR_W-1:0] tag_rd_ff;
   logic [ST_W-1:0]                 st_rd_ff;

   logic                            mem_we;
   logic [SET_W-1:0]                wr_set;
   logic [MAX_WAYS-1:0][ADDR_W-1:0] wr_tags;
   logic [MAX_WAYS-1:0]             wr_valid;
   logic [MAX_WAYS-1:0][REC_W-1:0]  wr_rec;

   // address split
   logic [SHIFT_W-1:0] sb_eff;
   logic [SHIFT_W-1:0] tag_shift;
   logic [ADDR_W-1:0]  addr_shifted;
   logic [SET_W-1:0]   set_mask;
   logic [SET_W-1:0]   req_set;
   logic [ADDR_W-1:0]  req_tag;
   logic [NW_W-1:0]    nways_eff;

   // lookup
   logic [MAX_WAYS-1:0]             rd_valid;
   logic [MAX_WAYS-1:0][REC_W-1:0]  rd_rec;
   lookup_flags_type                lk_flags;
   logic [MAX_WAYS-1:0]             lk_valid;
   logic [MAX_WAYS-1:0][REC_W-1:0]  lk_rec;
   logic [MAX_WAYS-1:0][ADDR_W-1:0] lk_tags;

   always_comb begin
      if (SHIFT_W'(set_bits_ff) > SHIFT_W'(MAX_SET_BITS)) begin
         sb_eff = SHIFT_W'(MAX_SET_BITS);
      end else begin
         sb_eff = SHIFT_W'(set_bits_ff);
      end
      tag_shift    = SHIFT_W'(block_bits_ff) + sb_eff;
      addr_shifted = req_address >> block_bits_ff;
      for (int i = 0; i < SET_W; i++) begin
         set_mask[i] = (SHIFT_W'(i) < sb_eff);
      end
      req_set = addr_shifted[SET_W-1:0] & set_mask;
      if (tag_shift >= SHIFT_W'(ADDR_W)) begin
         req_tag = '0;
      end else begin
         req_tag = req_address >> tag_shift[5:0];
      end
   end

   always_comb begin
      priority if (ways_ff == 4'd0) begin
         nways_eff = NW_W'(1);
      end else if ({1'b0, ways_ff} > 5'(MAX_WAYS)) begin
         nways_eff = NW_W'(MAX_WAYS);
      end else begin
         nways_eff = NW_W'(ways_ff);
      end
   end

   assign rd_valid = st_rd_ff[ST_W-1 -: MAX_WAYS];
   assign rd_rec   = st_rd_ff[MAX_WAYS*REC_W-1:0];

   salru_lookup #(
      .MAX_WAYS (MAX_WAYS)
   ) u_lookup (
      .nways     (nways_eff),
      .tag       (tag_ff),
      .valid     (rd_valid),
      .rec       (rd_rec),
      .tags      (tag_rd_ff),
      .flags     (lk_flags),
      .new_valid (lk_valid),
      .new_rec   (lk_rec),
      .new_tags  (lk_tags)
   );

   always_ff @(posedge clock) begin
      if (mem_we) begin
         tag_mem[wr_set] <= wr_tags;
         st_mem[wr_set]  <= {wr_valid, wr_rec};
      end
      tag_rd_ff <= tag_mem[req_set];
      st_rd_ff  <= st_mem[req_set];
   end

   always_comb begin
      state_in     = state_ff;
      accept       = 1'b0;
      mem_we       = 1'b0;
      wr_set       = set_ff;
      wr_tags      = lk_tags;
      wr_valid     = lk_valid;
      wr_rec       = lk_rec;
      rsp_valid_in = 1'b0;
      rsp_hit_in   = 1'b0;
      rsp_evict_in = 1'b0;
      rsp_last_in  = 1'b0;
      hit_inc      = 1'b0;
      miss_inc     = 1'b0;
      evict_inc    = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            mem_we   = 1'b1;
            wr_set   = clr_cnt_ff;
            wr_tags  = '0;
            wr_valid = '0;
            wr_rec   = '0;
            if (clr_cnt_ff == SET_W'(NUM_SETS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_start) begin
               accept = 1'b1;
               if (req_operation != OP_NONE) begin
                  state_in = ST_LOOKUP;
               end
            end
         end
         ST_LOOKUP: begin
            mem_we       = 1'b1;
            rsp_valid_in = 1'b1;
            rsp_hit_in   = lk_flags.hit;
            rsp_evict_in = lk_flags.evict;
            rsp_last_in  = !modify_ff;
            hit_inc      = lk_flags.hit;
            miss_inc     = !lk_flags.hit;
            evict_inc    = lk_flags.evict;
            state_in     = modify_ff ? ST_SECOND : ST_IDLE;
         end
         ST_SECOND: begin
            // the line was just filled or touched: a hit that leaves the row as is
            rsp_valid_in = 1'b1;
            rsp_hit_in   = 1'b1;
            rsp_last_in  = 1'b1;
            hit_inc      = 1'b1;
            state_in     = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         hit_cnt_ff   <= '0;
         miss_cnt_ff  <= '0;
         evict_cnt_ff <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (state_ff == ST_CLEAR) begin
            clr_cnt_ff <= clr_cnt_ff + 1'b1;
         end
         if (hit_inc && (hit_cnt_ff != '1)) begin
            hit_cnt_ff <= hit_cnt_ff + 1'b1;
         end
         if (miss_inc && (miss_cnt_ff != '1)) begin
            miss_cnt_ff <= miss_cnt_ff + 1'b1;
         end
         if (evict_inc && (evict_cnt_ff != '1)) begin
            evict_cnt_ff <= evict_cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         set_bits_ff   <= 3'd0;
         block_bits_ff <= 6'd0;
         ways_ff       <= 4'd1;
      end else if (csr_wen) begin
         unique case (csr_index)
            CSR_SET_BITS:   set_bits_ff   <= csr_wdata[2:0];
            CSR_BLOCK_BITS: block_bits_ff <= csr_wdata[5:0];
            CSR_WAYS:       ways_ff       <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         set_ff    <= req_set;
         tag_ff    <= req_tag;
         modify_ff <= (req_operation == OP_MODIFY);
      end
      rsp_hit_ff   <= rsp_hit_in;
      rsp_evict_ff <= rsp_evict_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign req_busy            = (state_ff != ST_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_hit             = rsp_hit_ff;
   assign rsp_eviction        = rsp_evict_ff;
   assign rsp_last            = rsp_last_ff;
   assign rsp_hits_total      = RSP_CNT_W'(hit_cnt_ff);
   assign rsp_misses_total    = RSP_CNT_W'(miss_cnt_ff);
   assign rsp_evictions_total = RSP_CNT_W'(evict_cnt_ff);

endmodule

@@ hw/rtl/salru_checker.sv @@
// Port-level assertions for the set-associative LRU cache lookup unit.
// Depends on salru_pkg; bound to set_assoc_lru_cache_lookup_unit below.

module salru_checker
   import salru_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 req_start,
   input logic                 req_busy,
   input logic [OP_W-1:0]      req_operation,
   input logic                 rsp_valid,
   input logic                 rsp_hit,
   input logic                 rsp_eviction,
   input logic                 rsp_last,
   input logic [RSP_CNT_W-1:0] rsp_hits_total
);

   // clearing pass holds off requests after reset
   a_clear_busy: assert property (@(posedge clock) reset |=> req_busy)
      else $error("busy low right after reset");

   a_evict_miss: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_eviction |-> !rsp_hit)
      else $error("eviction reported on a hit");

   // the first result of a modify is followed by its second, a hit
   a_modify_second: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |=> rsp_valid && rsp_last && rsp_hit)
      else $error("modify second result missing or not a hit");

   a_single_latency: assert property (@(posedge clock) disable iff (reset)
      req_start && !req_busy && (req_operation == OP_LOAD || req_operation == OP_STORE)
      |-> ##2 (rsp_valid && rsp_last))
      else $error("load or store result not delivered two cycles after request");

   a_hits_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit |-> $stable(rsp_hits_total))
      else $error("hit count moved on a miss");

endmodule

bind set_assoc_lru_cache_lookup_unit salru_checker u_salru_checker (
   .clock          (clock),
   .reset          (reset),
   .req_start      (req_start),
   .req_busy       (req_busy),
   .req_operation  (req_operation),
   .rsp_valid      (rsp_valid),
   .rsp_hit        (rsp_hit),
   .rsp_eviction   (rsp_eviction),
   .rsp_last       (rsp_last),
   .rsp_hits_total (rsp_hits_total)
);
